[hw/rtl/keq_pkg.sv]
// ----------------------------------------------------------------------------
// keq_pkg
// Shared types and constants of the key event queue controller.
// ----------------------------------------------------------------------------
package keq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned MODS_W  = 10;
  localparam int unsigned EVENT_W = 16;
  localparam int unsigned SCAN_W  = 17;
  localparam int unsigned LEVEL_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_KEY   = 3'd0,
    KIND_ALLUP = 3'd1,
    KIND_DEQ   = 3'd2,
    KIND_CLR   = 3'd3,
    KIND_RAW   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  typedef struct packed {
    logic [SCAN_W-1:0]  scan;
    logic               ready;
    logic               irq;
    logic               drop;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage

[hw/rtl/keq_store.sv]
// ----------------------------------------------------------------------------
// keq_store
// Event storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module keq_store #(
  parameter int unsigned QUEUE_DEPTH = keq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [keq_pkg::EVENT_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [keq_pkg::EVENT_W-1:0] rdata_o
);
  import keq_pkg::*;

  logic [EVENT_W-1:0] mem_q [QUEUE_DEPTH];
  logic [EVENT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/key_event_queue_controller.sv]
// ----------------------------------------------------------------------------
// key_event_queue_controller
// Keyboard scan register with ready flag, interrupt pulse and event queue.
//
// Input words carry a kind (key event, all-up event, dequeue, clear ready,
// raw push) and its fields; they are taken when in_valid_i is high and
// in_stall_o is low. Every input word yields one result word on the output
// channel: scan register, ready flag, interrupt pulse, drop flag and queue
// level as they stand after the word.
// Most words are handled at once; their result is registered into the
// output or skid register. A dequeue that moves an entry reads the event
// memory and takes its registered read data in ST_READ, where the input stalls.
// Otherwise the rate is one word per cycle while the skid stage is empty.
// A skid register behind the output register lets one more word in while a
// result waits; with both full the input stalls until out_stall_i drops.
// Reset empties the queue, clears the scan register, ready flag and the
// interrupt enable; memory contents are not cleared and need no pass.
// cfg_we_i writes the interrupt enable bit.
// ----------------------------------------------------------------------------
module key_event_queue_controller #(
  parameter int unsigned QUEUE_DEPTH = keq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [keq_pkg::KIND_W-1:0]  kind_i,
  input  logic [keq_pkg::CODE_W-1:0]  key_code_i,
  input  logic                        key_released_i,
  input  logic [keq_pkg::MODS_W-1:0]  modifier_bits_i,
  input  logic [keq_pkg::EVENT_W-1:0] raw_event_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [keq_pkg::SCAN_W-1:0]  scan_value_o,
  output logic                        data_ready_o,
  output logic                        interrupt_request_o,
  output logic                        event_dropped_o,
  output logic [keq_pkg::LEVEL_W-1:0] queue_level_o
);
  import keq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [LW-1:0] FULL_LVL  = LW'(QUEUE_DEPTH);

  state_e state_q, state_d;
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [LW-1:0] level_q, level_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic ready_q, ready_d;
  logic ie_q;
  logic irq_pend_q, irq_pend_d;

  result_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;
  logic res_valid, take, accept;

  logic wr_en, rd_en;
  logic [EVENT_W-1:0] wr_data, rd_data, ev;
  logic irq, drop;

  keq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wptr_q),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rptr_q),
    .rdata_o(rd_data)
  );

  assign in_stall_o = (state_q != ST_IDLE) || skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = out_valid_q && !out_stall_i;

  always_comb begin
    state_d    = state_q;
    wptr_d     = wptr_q;
    rptr_d     = rptr_q;
    level_d    = level_q;
    scan_d     = scan_q;
    ready_d    = ready_q;
    irq_pend_d = irq_pend_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    irq        = 1'b0;
    drop       = 1'b0;
    res_valid  = 1'b0;
    ev         = raw_event_i;
    if (kind_i == KIND_KEY) begin
      ev = {7'd0, key_released_i, key_code_i};
    end else if (kind_i == KIND_ALLUP) begin
      ev = {1'b1, 5'd0, modifier_bits_i};
    end
    wr_data = ev;

    if (state_q == ST_READ) begin
      scan_d    = {1'b1, rd_data};
      irq       = irq_pend_q;
      res_valid = 1'b1;
      state_d   = ST_IDLE;
    end else if (accept) begin
      res_valid = 1'b1;
      unique case (kind_i)
        KIND_KEY, KIND_ALLUP, KIND_RAW: begin
          if (ready_q || kind_i == KIND_RAW) begin
            if (level_q != FULL_LVL) begin
              wr_en   = 1'b1;
              level_d = level_q + 1'b1;
              wptr_d  = (wptr_q == LAST_ADDR) ? '0 : wptr_q + 1'b1;
            end else begin
              drop = 1'b1;
              if (!ready_q && ie_q) begin
                ready_d = 1'b1;
                irq     = 1'b1;
              end
            end
          end else begin
            scan_d = {1'b1, ev};
            if (ie_q) begin
              ready_d = 1'b1;
              irq     = 1'b1;
            end
          end
        end
        KIND_DEQ: begin
          if (!ready_q && level_q != '0) begin
            rd_en      = 1'b1;
            rptr_d     = (rptr_q == LAST_ADDR) ? '0 : rptr_q + 1'b1;
            level_d    = level_q - 1'b1;
            ready_d    = ie_q;
            irq_pend_d = ie_q;
            res_valid  = 1'b0;
            state_d    = ST_READ;
          end
        end
        KIND_CLR: begin
          ready_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    res.scan  = scan_d;
    res.ready = ready_d;
    res.irq   = irq;
    res.drop  = drop;
    res.level = LEVEL_W'(level_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wptr_q     <= '0;
      rptr_q     <= '0;
      level_q    <= '0;
      scan_q     <= '0;
      ready_q    <= 1'b0;
      ie_q       <= 1'b0;
      irq_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      wptr_q     <= wptr_d;
      rptr_q     <= rptr_d;
      level_q    <= level_d;
      scan_q     <= scan_d;
      ready_q    <= ready_d;
      irq_pend_q <= irq_pend_d;
      if (cfg_we_i) begin
        ie_q <= cfg_wdata_i;
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      if (out_valid_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign scan_value_o        = out_q.scan;
  assign data_ready_o        = out_q.ready;
  assign interrupt_request_o = out_q.irq;
  assign event_dropped_o     = out_q.drop;
  assign queue_level_o       = out_q.level;

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= FULL_LVL)
    else $error("queue level above depth");

  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == '0 || level_q == FULL_LVL) |-> wptr_q == rptr_q)
    else $error("pointers disagree with queue level");

  a_skid_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word without output word");

  a_read_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> state_q == ST_READ ##1 state_q == ST_IDLE)
    else $error("dequeue read did not complete in one cycle");

endmodule

[dv/key_event_queue_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_queue_controller_tb
// Self-checking bench for the keyboard scan register and event queue.
//
// A queue of pending words feeds a clocked driver. A clocked monitor runs a
// behavioral copy of the controller on every accepted word and compares each
// result word, field by field, against the oldest prediction. Directed words
// cover the field extremes, every kind and the corner cases. Random phases
// then sweep the interrupt enable, sender idling, receiver stalls, a long
// receiver hold-off and a full drain before going on.
// ----------------------------------------------------------------------------
module key_event_queue_controller_tb;
  import keq_pkg::*;

  localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned HOLD_LEN    = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          MODE_MIX    = 0;
  localparam int          MODE_FILL   = 1;
  localparam int          MODE_DRAIN  = 2;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [CODE_W-1:0]  code;
    logic               rel;
    logic [MODS_W-1:0]  mods;
    logic [EVENT_W-1:0] raw;
  } kbd_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [KIND_W-1:0]    kind_i;
  logic [CODE_W-1:0]    key_code_i;
  logic                 key_released_i;
  logic [MODS_W-1:0]    modifier_bits_i;
  logic [EVENT_W-1:0]   raw_event_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [SCAN_W-1:0]    scan_value_o;
  logic                 data_ready_o;
  logic                 interrupt_request_o;
  logic                 event_dropped_o;
  logic [LEVEL_W-1:0]   queue_level_o;

  kbd_word_t pending_words[$];
  result_t   expected_status[$];
  kbd_word_t drv_word;
  logic      in_taken;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned n_words;
  int unsigned n_drops;
  int unsigned n_irqs;
  int unsigned n_in_stalls;
  int unsigned peak_level;

  // predicted controller state
  logic [SCAN_W-1:0] event_mem[DEPTH];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  int unsigned       free_cnt;
  logic [SCAN_W-1:0] scan_reg;
  logic              ready_q;
  logic              irq_en;
  logic              irq_p;
  logic              drop_p;

  key_event_queue_controller u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind_i),
    .key_code_i          (key_code_i),
    .key_released_i      (key_released_i),
    .modifier_bits_i     (modifier_bits_i),
    .raw_event_i         (raw_event_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .scan_value_o        (scan_value_o),
    .data_ready_o        (data_ready_o),
    .interrupt_request_o (interrupt_request_o),
    .event_dropped_o     (event_dropped_o),
    .queue_level_o       (queue_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    in_valid_i      = 1'b0;
    kind_i          = '0;
    key_code_i      = '0;
    key_released_i  = 1'b0;
    modifier_bits_i = '0;
    raw_event_i     = '0;
    out_stall_i     = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_req        = 0;
    hold_seen       = 0;
    hold_left       = 0;
    cycle_cnt       = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic push_evt(input logic [EVENT_W-1:0] ev);
    if (free_cnt > 0) begin
      free_cnt--;
      event_mem[wr_ptr] = {1'b1, ev};
      wr_ptr = (wr_ptr + 1) % DEPTH;
    end else begin
      drop_p = 1'b1;
      if (!ready_q && irq_en) begin
        ready_q = 1'b1;
        irq_p   = 1'b1;
      end
    end
  endtask

  task automatic post_evt(input logic [EVENT_W-1:0] ev);
    if (ready_q) begin
      push_evt(ev);
    end else begin
      scan_reg = {1'b1, ev};
      if (irq_en) begin
        ready_q = 1'b1;
        irq_p   = 1'b1;
      end
    end
  endtask

  task automatic apply_kbd_word(input kbd_word_t w, output result_t r);
    irq_p  = 1'b0;
    drop_p = 1'b0;
    case (w.kind)
      KIND_KEY:   post_evt({7'd0, w.rel, w.code});
      KIND_ALLUP: post_evt({1'b1, 5'd0, w.mods});
      KIND_DEQ: begin
        if (!ready_q && free_cnt < DEPTH) begin
          scan_reg = event_mem[rd_ptr];
          rd_ptr   = (rd_ptr + 1) % DEPTH;
          free_cnt++;
          if (irq_en) begin
            ready_q = 1'b1;
            irq_p   = 1'b1;
          end
        end
      end
      KIND_CLR:   ready_q = 1'b0;
      KIND_RAW:   push_evt(w.raw);
      default: ;
    endcase
    r.scan  = scan_reg;
    r.ready = ready_q;
    r.irq   = irq_p;
    r.drop  = drop_p;
    r.level = LEVEL_W'(DEPTH - free_cnt);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv_word = pending_words.pop_front();
        in_valid_i      <= 1'b1;
        kind_i          <= drv_word.kind;
        key_code_i      <= drv_word.code;
        key_released_i  <= drv_word.rel;
        modifier_bits_i <= drv_word.mods;
        raw_event_i     <= drv_word.raw;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    kbd_word_t w;
    result_t   r;
    result_t   want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
      wr_ptr   = 0;
      rd_ptr   = 0;
      free_cnt = DEPTH;
      scan_reg = '0;
      ready_q  = 1'b0;
      irq_en   = 1'b0;
      irq_p    = 1'b0;
      drop_p   = 1'b0;
      err_cnt  = 0;
      n_words  = 0;
      n_drops  = 0;
      n_irqs   = 0;
      n_in_stalls = 0;
      peak_level  = 0;
      expected_status.delete();
    end else begin
      if (cfg_we_i)
        irq_en = cfg_wdata_i;
      if (in_valid_i && in_stall_o)
        n_in_stalls++;
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        w.kind = kind_i;
        w.code = key_code_i;
        w.rel  = key_released_i;
        w.mods = modifier_bits_i;
        w.raw  = raw_event_i;
        apply_kbd_word(w, r);
        expected_status.push_back(r);
        n_words++;
        if (r.drop) n_drops++;
        if (r.irq) n_irqs++;
        if (32'(r.level) > peak_level) peak_level = 32'(r.level);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result word, scan %0h", $time, scan_value_o);
        end else begin
          want = expected_status.pop_front();
          check_field("scan_value", 32'(want.scan), 32'(scan_value_o));
          check_field("data_ready", 32'(want.ready), 32'(data_ready_o));
          check_field("interrupt_request", 32'(want.irq), 32'(interrupt_request_o));
          check_field("event_dropped", 32'(want.drop), 32'(event_dropped_o));
          check_field("queue_level", 32'(want.level), 32'(queue_level_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("key_event_queue_controller_tb failed");
      $finish;
    end
  end

  task automatic add_word(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                          input logic rel, input logic [MODS_W-1:0] mods,
                          input logic [EVENT_W-1:0] raw);
    kbd_word_t w;
    w.kind = kind;
    w.code = code;
    w.rel  = rel;
    w.mods = mods;
    w.raw  = raw;
    pending_words.push_back(w);
  endtask

  function automatic kbd_word_t rand_word(input int mode);
    kbd_word_t w;
    int unsigned pick;
    w.code = CODE_W'($urandom);
    w.rel  = 1'($urandom);
    w.mods = MODS_W'($urandom);
    w.raw  = EVENT_W'($urandom);
    pick   = $urandom_range(99);
    case (mode)
      MODE_FILL:
        w.kind = pick < 45 ? KIND_KEY : pick < 65 ? KIND_ALLUP : pick < 95 ? KIND_RAW : KIND_CLR;
      MODE_DRAIN:
        w.kind = pick < 45 ? KIND_CLR : pick < 90 ? KIND_DEQ : KIND_KEY;
      default: begin
        if (pick < 30)      w.kind = KIND_KEY;
        else if (pick < 42) w.kind = KIND_ALLUP;
        else if (pick < 64) w.kind = KIND_DEQ;
        else if (pick < 80) w.kind = KIND_CLR;
        else if (pick < 97) w.kind = KIND_RAW;
        else                w.kind = KIND_W'(KIND_RAW) + KIND_W'($urandom_range(1, 3));
      end
    endcase
    return w;
  endfunction

  task automatic gen_words(input int unsigned n);
    int unsigned len;
    int          mode;
    while (n > 0) begin
      mode = $urandom_range(MODE_DRAIN, MODE_MIX);
      len  = $urandom_range(4, 24);
      if (len > n) len = n;
      n -= len;
      repeat (len) pending_words.push_back(rand_word(mode));
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_irq_enable(input logic v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input logic ien, input int unsigned idle, input int unsigned stall,
                           input int unsigned n, input bit long_hold, input bit mid_pause);
    wait_drained();
    write_irq_enable(ien);
    @(posedge clk_i);
    idle_pct  = idle;
    stall_pct = stall;
    if (long_hold) hold_req++;
    if (mid_pause) begin
      gen_words(n / 2);
      wait_drained();
      gen_words(n - n / 2);
    end else begin
      gen_words(n);
    end
    wait_drained();
  endtask

  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // interrupts off: key and all-up events go straight to the scan register, raw events to the queue
    add_word(KIND_KEY,   8'h00, 1'b0, '0,        '0);
    add_word(KIND_KEY,   8'hff, 1'b1, '1,        '1);
    add_word(KIND_ALLUP, 8'h00, 1'b0, '0,        '0);
    add_word(KIND_ALLUP, 8'hff, 1'b1, '1,        '1);
    add_word(KIND_RAW,   8'h00, 1'b0, '0,        16'h0000);
    add_word(KIND_RAW,   8'h00, 1'b0, '0,        16'hffff);
    add_word(KIND_DEQ,   8'h00, 1'b0, '0,        '0);
    add_word(KIND_DEQ,   8'h00, 1'b0, '0,        '0);
    add_word(KIND_DEQ,   8'h00, 1'b0, '0,        '0);
    add_word(KIND_CLR,   8'h00, 1'b0, '0,        '0);
    add_word(KIND_W'(KIND_RAW) + KIND_W'(3), 8'h5a, 1'b1, 10'h2a5, 16'h1234);
    wait_drained();

    // interrupts on: fill the queue, overflow it with ready clear and set
    write_irq_enable(1'b1);
    @(posedge clk_i);
    add_word(KIND_KEY, 8'h1c, 1'b0, '0, '0);
    for (int i = 0; i < DEPTH; i++)
      add_word(KIND_KEY, CODE_W'(i * 17), 1'(i), '0, '0);
    add_word(KIND_CLR, 8'h00, 1'b0, '0, '0);
    add_word(KIND_RAW, 8'h00, 1'b0, '0, 16'h8001);
    add_word(KIND_KEY, 8'h33, 1'b0, '0, '0);
    add_word(KIND_DEQ, 8'h00, 1'b0, '0, '0);
    add_word(KIND_CLR, 8'h00, 1'b0, '0, '0);
    add_word(KIND_DEQ, 8'h00, 1'b0, '0, '0);
    wait_drained();

    run_phase(1'b1, 0,  0,  120, 1'b1, 1'b0);
    run_phase(1'b0, 85, 0,  110, 1'b0, 1'b0);
    run_phase(1'b1, 0,  85, 110, 1'b0, 1'b0);
    run_phase(1'b1, 11, 11, 130, 1'b0, 1'b0);
    run_phase(1'b0, 0,  0,  120, 1'b0, 1'b1);
    run_phase(1'b1, 85, 0,  110, 1'b0, 1'b0);
    run_phase(1'b0, 0,  85, 100, 1'b0, 1'b0);
    run_phase(1'b0, 11, 11, 50,  1'b0, 1'b0);
    repeat (10) @(posedge clk_i);

    $display("covered %0d words with interrupts on and off: %0d drops, %0d interrupts",
             n_words, n_drops, n_irqs);
    $display("peak queue level %0d, input stalled %0d cycles, %0d mismatches",
             peak_level, n_in_stalls, err_cnt);
    if (err_cnt == 0 && expected_status.size() == 0) begin
      $display("key_event_queue_controller_tb passed");
    end else begin
      $display("key_event_queue_controller_tb failed");
    end
    $finish;
  end

endmodule
